>>> design/mmms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving mean minus sample: shared package
// Holds the sequencer state type and the fixed width of the window register.
// ----------------------------------------------------------------------------
package mmms_pkg;

  localparam int WLEN_W = 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

>>> design/mmms_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving mean minus sample: iterative divider
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmms_div #(
  parameter int DVD_W = 24,
  parameter int DVS_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_new;
  logic             ge;

  always_comb begin
    rem_sh  = {rem, quo[DVD_W-1]};
    ge      = rem_sh >= {1'b0, divisor};
    rem_new = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(DVD_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (run) begin
      quo <= {quo[DVD_W-2:0], ge};
      rem <= rem_new[DVS_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

>>> design/moving_mean_minus_sample_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving mean minus sample
// Keeps a window of signed samples in a ring memory with a running sum and
// reports the window mean and the mean minus each new sample.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the s_ stream, one word per sample. Each word yields one
// result word on the m_ stream carrying the truncated window mean and the
// mean minus the sample. The window length register is written through
// cfg_wen and cfg_wdata only while the block is idle, a rule for the user
// that the block does not enforce. A write clears the running sum, the write
// position and fill count. Zero acts as one sample, above WINDOW_MAX as WINDOW_MAX.
// One sample is processed at a time: a ring memory read, a read-modify-write
// of the sum, then an iterative divider taking one quotient bit per cycle.
// An item passes through the update, start, divide and output states from accept
// to result, and a new sample is taken once the sequencer is back in idle.
// The output register lets the next sample be accepted while a result still
// waits; if the receiver stalls, a finished result waits in the sequencer.
// Reset clears all control state and the window length returns to 256.
// Unwritten ring entries read as zero through the fill count, so no memory
// clearing pass is needed.
// ----------------------------------------------------------------------------
module moving_mean_minus_sample_unit #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // Fields from bit 0: sample.
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // Fields from bit 0: window_mean, mean_minus_sample.
  output logic [((2*SAMPLE_BITS+8)/8)*8-1:0]    m_tdata,
  input  logic                                  cfg_wen,
  input  logic [mmms_pkg::WLEN_W-1:0]           cfg_wdata
);

  localparam int M_DATA_W = ((2 * SAMPLE_BITS + 8) / 8) * 8;
  localparam int AW       = $clog2(WINDOW_MAX);
  localparam int WIN_W    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W    = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int DIFF_W   = SAMPLE_BITS + 1;

  mmms_pkg::state_t state, state_next;

  logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [mmms_pkg::WLEN_W-1:0]   window_length;
  logic [AW-1:0]                 wpos;
  logic [WIN_W-1:0]              fill;
  logic signed [SUM_W-1:0]       sum;
  logic                          neg;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic signed [DIFF_W-1:0]      diff;

  logic [WIN_W-1:0]              win;
  logic [WIN_W-1:0]              pos_inc;
  logic signed [SAMPLE_BITS-1:0] old;
  logic signed [SUM_W-1:0]       sum_next;
  logic [SUM_W-1:0]              dividend;
  logic [SUM_W-1:0]              quotient;
  logic signed [SUM_W-1:0]       quo_s;
  logic signed [SAMPLE_BITS-1:0] mean_next;
  logic signed [DIFF_W-1:0]      diff_next;
  logic                          s_acc;
  logic                          div_start;
  logic                          div_done;
  logic                          load_out;

  always_comb begin
    if (window_length == '0) begin
      win = WIN_W'(1);
    end else if (32'(window_length) > WINDOW_MAX) begin
      win = WIN_W'(WINDOW_MAX);
    end else begin
      win = WIN_W'(window_length);
    end
    pos_inc   = WIN_W'(wpos) + WIN_W'(1);
    old       = (fill == win) ? rd_data : '0;
    sum_next  = sum - SUM_W'(old) + SUM_W'(sample);
    dividend  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    quo_s     = neg ? -$signed(quotient) : $signed(quotient);
    mean_next = quo_s[SAMPLE_BITS-1:0];
    diff_next = DIFF_W'(mean_next) - DIFF_W'(sample);
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      mmms_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = mmms_pkg::ST_UPDATE;
        end
      end
      mmms_pkg::ST_UPDATE: begin
        state_next = mmms_pkg::ST_START;
      end
      mmms_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = mmms_pkg::ST_DIV;
      end
      mmms_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = mmms_pkg::ST_OUT;
        end
      end
      mmms_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = mmms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mmms_pkg::ST_IDLE;
      end
    endcase
  end

  assign s_acc = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      rd_data <= ring[wpos];
      sample  <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (state == mmms_pkg::ST_UPDATE) begin
      ring[wpos] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= mmms_pkg::WLEN_W'(256);
      wpos          <= '0;
      fill          <= '0;
      sum           <= '0;
    end else if (cfg_wen) begin
      window_length <= cfg_wdata;
      wpos          <= '0;
      fill          <= '0;
      sum           <= '0;
    end else if (state == mmms_pkg::ST_UPDATE) begin
      sum  <= sum_next;
      wpos <= (pos_inc >= win) ? '0 : pos_inc[AW-1:0];
      if (fill < win) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == mmms_pkg::ST_START) begin
      neg <= sum[SUM_W-1];
    end
    if (load_out) begin
      mean <= mean_next;
      diff <= diff_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = M_DATA_W'({diff, mean});

  mmms_div #(
    .DVD_W(SUM_W),
    .DVS_W(WIN_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dividend),
    .divisor (fill),
    .done    (div_done),
    .quotient(quotient)
  );

endmodule

>>> design/mmms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving mean minus sample: port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module mmms_checker #(
  parameter int DATA_W = 40
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled output word changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("Input taken again while a sample was in work.");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("Result appeared without a sample in work.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Output valid after reset.");

endmodule

bind moving_mean_minus_sample_unit mmms_checker #(
  .DATA_W(M_DATA_W)
) u_mmms_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
